// File: hdl/cotst_pkg.sv
// Shared types, constants and tables of the circle collision tester.
`default_nettype none

package cotst_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CNT_W        = 6;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_CX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_CY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_ANG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_X    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_Y    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_R    = 3'd7;

    localparam logic ACT_CIRCLE = 1'b0;
    localparam logic ACT_BOX    = 1'b1;

    localparam logic [20:0] RAD_PER_UNIT_Q30 = 21'd1171271;
    localparam logic [23:0] GAIN_Q24         = 24'd10188014;

    localparam int MUL_A_W   = 41;
    localparam int MUL_B_W   = 33;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 6;

    localparam int DIV_N_W   = 62;
    localparam int DIV_D_W   = 31;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_C0_CHK, S_C0_A, S_C0_B, S_C0_R,
        S_ANGLE, S_ROT, S_GAIN_X, S_GAIN_Y, S_CLAMP, S_BOX_CHK,
        S_SQ_X, S_SQ_Y, S_SQRT, S_SQRT_CMP,
        S_NUM_X, S_DIV_X, S_NUM_Y, S_DIV_Y, S_FINISH
    } t_state;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000008;
            5'd28: v = 30'h00000004;
            5'd29: v = 30'h00000002;
            5'd30: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/cotst_mul.sv
// Bit-serial multiplier: signed multiplicand times unsigned multiplier, one bit per cycle.
`default_nettype none

module cotst_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [cotst_pkg::MUL_A_W-1:0]  i_a,
    input  logic [cotst_pkg::MUL_B_W-1:0]         i_b,
    output logic                                  o_done,
    output logic signed [cotst_pkg::MUL_P_W-1:0]  o_prod
);
    import cotst_pkg::*;

    logic                        r_busy;
    logic                        r_done;
    logic [MUL_CNT_W-1:0]        r_cnt;
    logic signed [MUL_A_W-1:0]   r_a;
    logic signed [MUL_A_W:0]     r_hi;
    logic [MUL_B_W-1:0]          r_lo;
    logic signed [MUL_A_W:0]     w_sum;

    // Add the multiplicand when the low multiplier bit is set, then shift one place.
    assign w_sum = r_hi + (r_lo[0] ? {r_a[MUL_A_W-1], r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= w_sum >>> 1;
            r_lo <= {w_sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[MUL_A_W-1:0], r_lo};

endmodule

`default_nettype wire

// File: hdl/cotst_div.sv
// Restoring divider: one quotient bit per cycle, unsigned.
`default_nettype none

module cotst_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cotst_pkg::DIV_N_W-1:0]  i_num,
    input  logic [cotst_pkg::DIV_D_W-1:0]  i_den,
    output logic                           o_done,
    output logic [cotst_pkg::DIV_N_W-1:0]  o_quot
);
    import cotst_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DIV_D_W-1:0]     r_rem;
    logic [DIV_D_W-1:0]     r_den;
    logic [DIV_N_W-1:0]     r_q;
    logic [DIV_D_W:0]       w_trial;
    logic                   w_fit;

    assign w_trial = {r_rem, r_q[DIV_N_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= w_fit ? DIV_D_W'(w_trial - {1'b0, r_den}) : w_trial[DIV_D_W-1:0];
            r_q   <= {r_q[DIV_N_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// File: hdl/circle_obb_collision_test.sv
// Top level of the circle collision tester: sequencer, CORDIC rotation and square root.
//
//  channel   direction   handshake                 payload
//  input     in          i_in_valid / o_in_stall   i_action, i_probe_x, i_probe_y,
//                                                  i_probe_radius
//  output    out         o_out_valid / i_out_stall o_hit, o_contact_out_x, o_contact_out_y
//  config    in          i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One beat is worked on at a time. A circle test runs the three squares in the bit-serial
// multiplier. A box test with a hit and a nonzero offset runs the CORDIC loop, four serial
// multiplies, the 32-step square root, and two more multiplies each feeding a 62-step
// division. Reset is synchronous and clears the configuration registers, the stored
// contact and the sequencer. The finished result waits in the output register; a new beat
// is taken while it is stalled, and only the next result waits for the output register
// to empty.
`default_nettype none

module circle_obb_collision_test (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_action,
    input  logic signed [31:0]                  i_probe_x,
    input  logic signed [31:0]                  i_probe_y,
    input  logic [30:0]                         i_probe_radius,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_hit,
    output logic signed [31:0]                  o_contact_out_x,
    output logic signed [31:0]                  o_contact_out_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cotst_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);
    import cotst_pkg::*;

    // Configuration registers.
    logic signed [31:0] r_box_cx, r_box_cy, r_own_x, r_own_y;
    logic signed [13:0] r_box_ang;
    logic [30:0]        r_half_w, r_half_h, r_own_r;

    // Latched beat and working registers.
    t_state             r_state, n_state;
    logic               r_action;
    logic signed [31:0] r_px, r_py;
    logic [30:0]        r_pr;
    logic signed [39:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic signed [12:0] r_ang;
    logic [CNT_W-1:0]   r_cnt;
    logic [31:0]        r_rs;
    logic signed [40:0] r_ex, r_ey;
    logic [63:0]        r_sq_a;
    logic [64:0]        r_s;
    logic [62:0]        r_sq_n;
    logic [62:0]        r_sq_bit;
    logic [63:0]        r_sq_res;
    logic               r_hit;
    logic signed [31:0] r_contact_x, r_contact_y;

    // Output register.
    logic               r_out_valid;
    logic               r_out_hit;
    logic signed [31:0] r_out_x, r_out_y;

    // Shared serial units.
    logic                       w_mul_start, w_mul_done;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic [MUL_B_W-1:0]         w_mul_b;
    logic signed [MUL_P_W-1:0]  w_prod;
    logic                       w_div_start, w_div_done;
    logic [DIV_N_W-1:0]         w_quot;

    logic w_accept, w_out_free;

    cotst_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    cotst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod[DIV_N_W-1:0]),
        .i_den   (r_sq_res[DIV_D_W-1:0]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Magnitudes and small derived values used across several states.
    logic [39:0]        w_abs_x, w_abs_y;
    logic [40:0]        w_abs_ex, w_abs_ey;
    logic [30:0]        w_pr_m;
    logic [31:0]        w_m;
    logic signed [MUL_P_W-1:0] w_round;
    logic signed [39:0] w_gain_out;

    assign w_abs_x    = r_x[39] ? 40'(-r_x) : 40'(r_x);
    assign w_abs_y    = r_y[39] ? 40'(-r_y) : 40'(r_y);
    assign w_abs_ex   = r_ex[40] ? 41'(-r_ex) : 41'(r_ex);
    assign w_abs_ey   = r_ey[40] ? 41'(-r_ey) : 41'(r_ey);
    assign w_m        = r_sq_res[31:0];
    assign w_pr_m     = r_pr - w_m[30:0];
    // Scale back by the CORDIC gain with round half up, then floor shift.
    assign w_round    = w_prod + MUL_P_W'(64'd1 << 27);
    assign w_gain_out = w_round[67:28];

    // Angle folding: negate the box angle and wrap it into one half turn either side.
    logic signed [15:0] w_wrap;
    always_comb begin
        w_wrap = -16'(r_box_ang);
        if (w_wrap < 0) w_wrap = w_wrap + 16'sd5760;
        if (w_wrap < 0) w_wrap = w_wrap + 16'sd5760;
        if (w_wrap >= 16'sd5760) w_wrap = w_wrap - 16'sd5760;
        if (w_wrap >= 16'sd2880) w_wrap = w_wrap - 16'sd5760;
    end

    // Beyond a quarter turn the offset is negated and the angle moves by half a turn.
    logic               w_flip;
    logic signed [12:0] w_ang_adj;
    logic signed [34:0] w_zp;
    always_comb begin
        w_flip    = 1'b0;
        w_ang_adj = r_ang;
        if (r_ang > 13'sd1440) begin
            w_flip    = 1'b1;
            w_ang_adj = r_ang - 13'sd2880;
        end else if (r_ang < -13'sd1440) begin
            w_flip    = 1'b1;
            w_ang_adj = r_ang + 13'sd2880;
        end
        w_zp = 35'(w_ang_adj) * 35'($signed({1'b0, RAD_PER_UNIT_Q30}));
    end

    // One CORDIC micro-rotation.
    logic [4:0]         w_idx;
    logic signed [39:0] w_xs, w_ys;
    assign w_idx = r_cnt[4:0];
    assign w_xs  = r_x >>> w_idx;
    assign w_ys  = r_y >>> w_idx;

    // One square root step.
    logic [63:0] w_sq_trial;
    logic        w_sq_fit;
    assign w_sq_trial = r_sq_res + {1'b0, r_sq_bit};
    assign w_sq_fit   = ({1'b0, r_sq_n} >= w_sq_trial);

    // Box clamp on the rotated offset.
    logic signed [40:0] w_u, w_v, w_hw, w_hh, w_ex, w_ey;
    always_comb begin
        w_u  = 41'(r_x);
        w_v  = 41'(r_y);
        w_hw = $signed({10'b0, r_half_w});
        w_hh = $signed({10'b0, r_half_h});
        if (w_u > w_hw)       w_ex = w_u - w_hw;
        else if (w_u < -w_hw) w_ex = w_u + w_hw;
        else                  w_ex = '0;
        if (w_v > w_hh)       w_ey = w_v - w_hh;
        else if (w_v < -w_hh) w_ey = w_v + w_hh;
        else                  w_ey = '0;
    end

    logic w_c0_near, w_box_near;
    assign w_c0_near  = (w_abs_x < {8'b0, r_rs}) && (w_abs_y < {8'b0, r_rs});
    assign w_box_near = (w_abs_ex < {10'b0, r_pr}) && (w_abs_ey < {10'b0, r_pr});

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // Next state. The rotation loop leaves its state only once the counter has passed its last
    // step, so that the gain multiply picks up the fully rotated offset.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_PREP;
            S_PREP:     n_state = (r_action == ACT_BOX) ? S_ANGLE : S_C0_CHK;
            S_C0_CHK:   n_state = w_c0_near ? S_C0_A : S_FINISH;
            S_C0_A:     if (w_mul_done) n_state = S_C0_B;
            S_C0_B:     if (w_mul_done) n_state = S_C0_R;
            S_C0_R:     if (w_mul_done) n_state = S_FINISH;
            S_ANGLE:    n_state = S_ROT;
            S_ROT:      if (r_cnt == CNT_W'(CORDIC_STEPS)) n_state = S_GAIN_X;
            S_GAIN_X:   if (w_mul_done) n_state = S_GAIN_Y;
            S_GAIN_Y:   if (w_mul_done) n_state = S_CLAMP;
            S_CLAMP:    n_state = S_BOX_CHK;
            S_BOX_CHK:  n_state = w_box_near ? S_SQ_X : S_FINISH;
            S_SQ_X:     if (w_mul_done) n_state = S_SQ_Y;
            S_SQ_Y:     if (w_mul_done) n_state = S_SQRT;
            S_SQRT:     if (r_sq_bit[0]) n_state = S_SQRT_CMP;
            S_SQRT_CMP: begin
                if ((w_m < {1'b0, r_pr}) && (r_s != '0)) n_state = S_NUM_X;
                else                                      n_state = S_FINISH;
            end
            S_NUM_X:    if (w_mul_done) n_state = S_DIV_X;
            S_DIV_X:    if (w_div_done) n_state = S_NUM_Y;
            S_NUM_Y:    if (w_mul_done) n_state = S_DIV_Y;
            S_DIV_Y:    if (w_div_done) n_state = S_FINISH;
            S_FINISH:   if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: unit launches and multiplier operands, chosen by the
    // state being entered so that each unit starts on the first cycle of its state.
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        if (n_state != r_state) begin
            case (n_state) inside
                S_C0_A, S_C0_B, S_C0_R, S_GAIN_X, S_GAIN_Y,
                S_SQ_X, S_SQ_Y, S_NUM_X, S_NUM_Y: w_mul_start = 1'b1;
                S_DIV_X, S_DIV_Y:                 w_div_start = 1'b1;
                default: ;
            endcase
        end
        case (n_state)
            S_C0_A: begin
                w_mul_a = $signed({1'b0, w_abs_x});
                w_mul_b = w_abs_x[MUL_B_W-1:0];
            end
            S_C0_B: begin
                w_mul_a = $signed({1'b0, w_abs_y});
                w_mul_b = w_abs_y[MUL_B_W-1:0];
            end
            S_C0_R: begin
                w_mul_a = $signed({9'b0, r_rs});
                w_mul_b = {1'b0, r_rs};
            end
            S_GAIN_X: begin
                w_mul_a = {r_x[39], r_x};
                w_mul_b = {9'b0, GAIN_Q24};
            end
            S_GAIN_Y: begin
                w_mul_a = {r_y[39], r_y};
                w_mul_b = {9'b0, GAIN_Q24};
            end
            S_SQ_X: begin
                w_mul_a = $signed({10'b0, w_abs_ex[30:0]});
                w_mul_b = {2'b0, w_abs_ex[30:0]};
            end
            S_SQ_Y: begin
                w_mul_a = $signed({10'b0, w_abs_ey[30:0]});
                w_mul_b = {2'b0, w_abs_ey[30:0]};
            end
            S_NUM_X: begin
                w_mul_a = $signed({10'b0, w_abs_ex[30:0]});
                w_mul_b = {2'b0, w_pr_m};
            end
            S_NUM_Y: begin
                w_mul_a = $signed({10'b0, w_abs_ey[30:0]});
                w_mul_b = {2'b0, w_pr_m};
            end
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_box_cx    <= '0;
            r_box_cy    <= '0;
            r_box_ang   <= '0;
            r_half_w    <= '0;
            r_half_h    <= '0;
            r_own_x     <= '0;
            r_own_y     <= '0;
            r_own_r     <= '0;
            r_contact_x <= '0;
            r_contact_y <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FINISH && w_out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall)                 r_out_valid <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_BOX_CX:  r_box_cx  <= i_cfg_data;
                    REG_BOX_CY:  r_box_cy  <= i_cfg_data;
                    REG_BOX_ANG: r_box_ang <= i_cfg_data[13:0];
                    REG_BOX_HW:  r_half_w  <= i_cfg_data[30:0];
                    REG_BOX_HH:  r_half_h  <= i_cfg_data[30:0];
                    REG_OWN_X:   r_own_x   <= i_cfg_data;
                    REG_OWN_Y:   r_own_y   <= i_cfg_data;
                    REG_OWN_R:   r_own_r   <= i_cfg_data[30:0];
                    default: ;
                endcase
            end

            // The stored contact changes only on a box hit.
            if (r_state == S_SQRT_CMP && w_m < {1'b0, r_pr} && r_s == '0) begin
                r_contact_x <= '0;
                r_contact_y <= '0;
            end
            if (r_state == S_DIV_X && w_div_done)
                r_contact_x <= (r_ex > 0) ? -w_quot[31:0] : w_quot[31:0];
            if (r_state == S_DIV_Y && w_div_done)
                r_contact_y <= (r_ey > 0) ? -w_quot[31:0] : w_quot[31:0];
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_px     <= i_probe_x;
            r_py     <= i_probe_y;
            r_pr     <= i_probe_radius;
            r_hit    <= 1'b0;
        end
        case (r_state)
            S_PREP: begin
                if (r_action == ACT_BOX) begin
                    r_x <= 40'(33'(r_px) - 33'(r_box_cx)) <<< 4;
                    r_y <= 40'(33'(r_py) - 33'(r_box_cy)) <<< 4;
                end else begin
                    r_x <= 40'(33'(r_px) - 33'(r_own_x));
                    r_y <= 40'(33'(r_py) - 33'(r_own_y));
                end
                r_ang <= w_wrap[12:0];
                r_rs  <= {1'b0, r_pr} + {1'b0, r_own_r};
            end
            S_C0_A: if (w_mul_done) r_sq_a <= w_prod[63:0];
            S_C0_B: if (w_mul_done) r_s <= {1'b0, r_sq_a} + {1'b0, w_prod[63:0]};
            S_C0_R: if (w_mul_done) r_hit <= (r_s < {1'b0, w_prod[63:0]});
            S_ANGLE: begin
                if (w_flip) begin
                    r_x <= -r_x;
                    r_y <= -r_y;
                end
                r_z   <= w_zp[33:0];
                r_cnt <= '0;
            end
            S_ROT: begin
                if (r_cnt != CNT_W'(CORDIC_STEPS)) begin
                    if (!r_z[33]) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - $signed({4'b0, atan_q30(w_idx)});
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + $signed({4'b0, atan_q30(w_idx)});
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_GAIN_X: if (w_mul_done) r_x <= w_gain_out;
            S_GAIN_Y: if (w_mul_done) r_y <= w_gain_out;
            S_CLAMP: begin
                r_ex <= w_ex;
                r_ey <= w_ey;
            end
            S_SQ_X: if (w_mul_done) r_sq_a <= w_prod[63:0];
            S_SQ_Y: begin
                if (w_mul_done) begin
                    r_s      <= {1'b0, r_sq_a} + {1'b0, w_prod[63:0]};
                    r_sq_n   <= 63'(r_sq_a + w_prod[63:0]);
                    r_sq_res <= '0;
                    r_sq_bit <= {1'b1, 62'b0};
                end
            end
            S_SQRT: begin
                if (w_sq_fit) begin
                    r_sq_n   <= r_sq_n - w_sq_trial[62:0];
                    r_sq_res <= (r_sq_res >> 1) + {1'b0, r_sq_bit};
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            S_SQRT_CMP: if (w_m < {1'b0, r_pr}) r_hit <= 1'b1;
            S_FINISH: begin
                if (w_out_free) begin
                    r_out_hit <= r_hit;
                    r_out_x   <= r_contact_x;
                    r_out_y   <= r_contact_y;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_contact_out_x = r_out_x;
    assign o_contact_out_y = r_out_y;

endmodule

`default_nettype wire
